>>> sv/assert_macros.svh
// Assertion helper macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must hold on every clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> sv/bdr_pkg.sv
// ----------------------------------------------------------------------------
// bdr_pkg
// Types and constants shared by the block download receiver.
// ----------------------------------------------------------------------------
package bdr_pkg;

    localparam logic [2:0] REQ_START    = 3'd0;
    localparam logic [2:0] REQ_DATA     = 3'd1;
    localparam logic [2:0] REQ_PROGRAM  = 3'd2;
    localparam logic [2:0] REQ_ACTIVATE = 3'd3;

    localparam logic [1:0] KIND_DATA_ACK = 2'd0;
    localparam logic [1:0] KIND_CHUNK    = 2'd1;
    localparam logic [1:0] KIND_PROG_ACK = 2'd2;
    localparam logic [1:0] KIND_FINISHED = 2'd3;

    localparam logic [0:0] CFG_POLY = 1'b0;
    localparam logic [0:0] CFG_INIT = 1'b1;

    localparam int unsigned MAX_LEN = 8;

    // Commands passed from the front end to the back end.
    typedef enum logic [3:0] {
        OP_WRITE    = 4'b0001,
        OP_CRC      = 4'b0010,
        OP_PROGRAM  = 4'b0100,
        OP_FINISHED = 4'b1000
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [5:0]  slot;
        logic [7:0]  byte_en;
        logic [63:0] data;
        logic [15:0] page;
    } t_cmd;

endpackage

>>> sv/bdr_front.sv
// ----------------------------------------------------------------------------
// bdr_front
// Accepts command words, tracks the session phase and the slot counter, and
// turns each acting data, program or activate word into one back-end command.
// ----------------------------------------------------------------------------
module bdr_front import bdr_pkg::*; #(
    parameter int unsigned SLOTS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_page_number,
    input  logic [3:0]  i_data_length,
    input  logic [63:0] i_data_bytes,
    output logic        o_cmd_valid,
    input  logic        i_cmd_ready,
    output t_cmd        o_cmd
);

    typedef enum logic [3:0] {
        PH_AWAIT    = 4'b0001,
        PH_RECV     = 4'b0010,
        PH_DONE     = 4'b0100,
        PH_FINISHED = 4'b1000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [6:0]  r_slot, n_slot;
    logic [15:0] r_page, n_page;
    logic        w_acc;
    logic [3:0]  w_len;

    // Input stalls whenever the queue is full, whether or not the word acts.
    assign o_ready = i_cmd_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_len   = (i_data_length > 4'(MAX_LEN)) ? 4'(MAX_LEN) : i_data_length;

    always_comb begin
        n_phase     = r_phase;
        n_slot      = r_slot;
        n_page      = r_page;
        o_cmd_valid = 1'b0;
        o_cmd.op    = OP_WRITE;
        o_cmd.slot  = 6'(r_slot - 7'd1);
        o_cmd.data  = i_data_bytes;
        o_cmd.page  = r_page;
        for (int b = 0; b < 8; b++) begin
            o_cmd.byte_en[b] = (4'(b) < w_len);
        end
        case (r_phase)
            PH_AWAIT: begin
                if (i_req_type == REQ_START) begin
                    n_page  = i_page_number;
                    n_slot  = 7'd1;
                    n_phase = PH_RECV;
                end else if (i_req_type == REQ_ACTIVATE) begin
                    n_phase     = PH_FINISHED;
                    o_cmd.op    = OP_FINISHED;
                    o_cmd_valid = i_valid;
                end
            end
            PH_RECV: begin
                if (i_req_type == REQ_DATA) begin
                    o_cmd_valid = i_valid;
                    if (r_slot == 7'(SLOTS)) begin
                        o_cmd.op = OP_CRC;
                        n_slot   = 7'd1;
                        n_phase  = PH_DONE;
                    end else begin
                        n_slot = r_slot + 7'd1;
                    end
                end
            end
            PH_DONE: begin
                if (i_req_type == REQ_PROGRAM) begin
                    o_cmd.op    = OP_PROGRAM;
                    o_cmd_valid = i_valid;
                    n_phase     = PH_AWAIT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_AWAIT;
            r_slot  <= 7'd1;
            r_page  <= 16'd0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_slot  <= n_slot;
            r_page  <= n_page;
        end
    end

endmodule

>>> sv/bdr_queue.sv
// ----------------------------------------------------------------------------
// bdr_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module bdr_queue import bdr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

endmodule

>>> sv/bdr_back.sv
// ----------------------------------------------------------------------------
// bdr_back
// Holds the page buffer, computes the block CRC one byte per cycle and
// streams flash-write chunks through a one-word output register.
// ----------------------------------------------------------------------------
module bdr_back import bdr_pkg::*; #(
    parameter int unsigned SLOTS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [15:0]  i_poly,
    input  logic [15:0]  i_init,
    input  logic         i_cmd_valid,
    output logic         o_cmd_ready,
    input  t_cmd         i_cmd,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [103:0] o_data,
    output logic         o_last
);

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned BW = SW + 3;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CRC  = 5'b00010,
        ST_RD   = 5'b00100,
        ST_OUT  = 5'b01000,
        ST_EMIT = 5'b10000
    } t_st;

    logic [63:0]   r_word [SLOTS];
    logic [7:0]    r_rbyte;
    logic [63:0]   r_rword;
    t_st           r_st;
    logic [BW-1:0] r_bidx;
    logic [SW:0]   r_cidx;
    logic [15:0]   r_crc;
    logic [15:0]   r_page;
    logic          r_first;
    logic          r_ovalid;
    logic [103:0]  r_odata;
    logic          r_olast;
    logic          w_ofree;
    logic          w_oload;
    logic [15:0]   w_crc;
    logic [SW-1:0] w_wslot;

    assign w_ofree     = !r_ovalid || i_ready;
    assign o_valid     = r_ovalid;
    assign o_data      = r_odata;
    assign o_last      = r_olast;
    assign o_cmd_ready = (r_st == ST_IDLE) && w_ofree;
    assign w_wslot     = i_cmd.slot[SW-1:0];

    // A new result word is loaded into the output register this cycle.
    assign w_oload = (o_cmd_ready && i_cmd_valid && (i_cmd.op == OP_FINISHED)) ||
                     ((r_st == ST_EMIT) && !r_first && w_ofree) ||
                     ((r_st == ST_OUT) && w_ofree);

    // Page buffer, one 64-bit word per slot with byte enables.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) r_word[s] <= 64'd0;
        end else if (i_cmd_valid && o_cmd_ready &&
                     (i_cmd.op == OP_WRITE || i_cmd.op == OP_CRC)) begin
            for (int b = 0; b < 8; b++) begin
                if (i_cmd.byte_en[b]) r_word[w_wslot][8*b +: 8] <= i_cmd.data[8*b +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rbyte <= r_word[r_bidx[BW-1:3]][8*r_bidx[2:0] +: 8];
        r_rword <= r_word[r_cidx[SW-1:0]];
    end

    // One CRC byte step: eight shift/xor steps on 16 bits.
    always_comb begin
        w_crc = r_crc ^ {r_rbyte, 8'd0};
        for (int k = 0; k < 8; k++) begin
            w_crc = w_crc[15] ? ((w_crc << 1) ^ i_poly) : (w_crc << 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_oload) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_bidx   <= '0;
            r_cidx   <= '0;
            r_first  <= 1'b0;
        end else begin
            case (r_st)
                ST_IDLE: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        r_page <= i_cmd.page;
                        case (i_cmd.op)
                            OP_CRC: begin
                                r_st    <= ST_CRC;
                                r_bidx  <= '0;
                                r_crc   <= i_init;
                                r_first <= 1'b1;
                            end
                            OP_PROGRAM: begin
                                r_st   <= ST_RD;
                                r_cidx <= '0;
                            end
                            OP_FINISHED: begin
                                r_odata <= {64'd0, 5'd0, i_cmd.page, 16'd0, 1'b0,
                                            KIND_FINISHED};
                                r_olast <= 1'b1;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_CRC: begin
                    // The first cycle only loads the read register.
                    if (!r_first) r_crc <= w_crc;
                    r_first <= !r_first && (r_bidx == BW'(SLOTS * 8 - 1));
                    if (r_bidx == BW'(SLOTS * 8 - 1)) begin
                        if (!r_first) r_st <= ST_EMIT;
                    end else begin
                        r_bidx <= r_bidx + BW'(1);
                    end
                end
                ST_EMIT: begin
                    if (r_first) begin
                        // Last byte is being read this cycle.
                        r_crc   <= w_crc;
                        r_first <= 1'b0;
                    end else if (w_ofree) begin
                        r_odata  <= {64'd0, 5'd0, r_page, r_crc, 1'b0, KIND_DATA_ACK};
                        r_olast  <= 1'b1;
                        r_st     <= ST_IDLE;
                    end
                end
                ST_RD: begin
                    r_st <= ST_OUT;
                end
                ST_OUT: begin
                    if (w_ofree) begin
                        if (r_cidx == (SW+1)'(SLOTS)) begin
                            r_odata <= {64'd0, 5'd0, r_page, 16'd0, 1'b0, KIND_PROG_ACK};
                            r_olast <= 1'b1;
                            r_st    <= ST_IDLE;
                        end else begin
                            r_odata <= {r_rword, 5'(r_cidx), r_page, 16'd0, 1'b0, KIND_CHUNK};
                            r_olast <= 1'b0;
                            r_cidx  <= r_cidx + (SW+1)'(1);
                            r_st    <= ST_RD;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> sv/block_download_receiver.sv
// ----------------------------------------------------------------------------
// block_download_receiver
// Firmware page receiver with CRC-16 acknowledgement and chunked programming.
// A word is taken each cycle while the command queue has room. An activate
// word gives a finished ack through the queue and the output register. The
// final data word starts a CRC pass of one byte per cycle, then its ack is
// loaded into the output register. A program word streams BLOCK_BYTES/8
// chunks plus an ack, each read from the page buffer first. Synchronous
// active-low reset clears phase, counters, CRC settings and the page buffer.
// ----------------------------------------------------------------------------
module block_download_receiver import bdr_pkg::*; #(
    parameter int unsigned BLOCK_BYTES = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: page_number[15:0], data_length[19:16], data_bytes[83:20],
    //        zero fill to 88
    input  logic [87:0]  s_axis_tdata,
    // tuser: req_type[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: block_crc[15:0], page_out[31:16], chunk_index[36:32],
    //        chunk_data[100:37], zero fill to 104
    output logic [103:0] m_axis_tdata,
    // tuser: result_kind[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int unsigned SLOTS = BLOCK_BYTES / 8;

    logic [15:0]  r_poly, r_init;
    logic         w_fvalid, w_fready, w_bvalid, w_bready;
    t_cmd         w_fcmd, w_bcmd;
    logic [103:0] w_bdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= 16'h1021;
            r_init <= 16'hFFFF;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_POLY) r_poly <= i_cfg_data;
            if (i_cfg_index == CFG_INIT) r_init <= i_cfg_data;
        end
    end

    bdr_front #(.SLOTS(SLOTS)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_req_type(s_axis_tuser), .i_page_number(s_axis_tdata[15:0]),
        .i_data_length(s_axis_tdata[19:16]), .i_data_bytes(s_axis_tdata[83:20]),
        .o_cmd_valid(w_fvalid), .i_cmd_ready(w_fready), .o_cmd(w_fcmd)
    );

    bdr_queue u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_fvalid), .o_ready(w_fready), .i_cmd(w_fcmd),
        .o_valid(w_bvalid), .i_ready(w_bready), .o_cmd(w_bcmd)
    );

    bdr_back #(.SLOTS(SLOTS)) u_back (
        .i_clk, .i_rst_n, .i_poly(r_poly), .i_init(r_init),
        .i_cmd_valid(w_bvalid), .o_cmd_ready(w_bready), .i_cmd(w_bcmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(w_bdata), .o_last(m_axis_tlast)
    );

    // Back end packs kind in the low two bits and the rest from bit 3 up.
    assign m_axis_tuser = w_bdata[1:0];
    assign m_axis_tdata = {3'd0, w_bdata[103:3]};

    `include "assert_macros.svh"

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
    `ASSERT_CLK(a_ack_last, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser != KIND_CHUNK |-> m_axis_tlast, "ack without last")
    `ASSERT_CLK(a_chunk_notlast, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tuser == KIND_CHUNK |-> !m_axis_tlast, "chunk marked last")
    `ASSERT_ALWAYS(a_reset_idle, i_clk,
        !i_rst_n |=> !m_axis_tvalid, "output valid right after reset")

endmodule

>>> test/tb_block_download_receiver.sv
// ----------------------------------------------------------------------------
// tb_block_download_receiver
// Self-checking testbench for the block download receiver. Command words are
// driven with random gaps. A scoreboard predicts the acknowledgements, flash
// chunks and finish words. Whole download sessions run with random payloads,
// mixed with stray commands, under several CRC settings.
// ----------------------------------------------------------------------------
module tb_block_download_receiver;
    import bdr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = 32;

    typedef enum logic [1:0] {
        PH_AWAIT, PH_RECV, PH_DONE, PH_FINISHED
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] crc;
        logic [15:0] page;
        logic [4:0]  idx;
        logic [63:0] chunk;
        logic        last;
    } t_result;

    class download_scoreboard;
        logic [15:0] poly;
        logic [15:0] init;
        t_phase      phase;
        int unsigned slot;
        logic [15:0] page;
        logic [63:0] buffer [SLOTS];
        t_result     pending [$];
        int          errors;

        function void clear();
            poly = 16'h1021;
            init = 16'hFFFF;
            phase = PH_AWAIT;
            slot = 1;
            page = '0;
            foreach (buffer[i]) buffer[i] = '0;
            errors = 0;
        endfunction

        function void configure(logic [0:0] index, logic [15:0] value);
            if (index == CFG_POLY) poly = value;
            else init = value;
        endfunction

        function logic [15:0] page_crc();
            logic [15:0] c;
            c = init;
            for (int j = 0; j < SLOTS * 8; j++) begin
                c ^= {buffer[j / 8][(j % 8) * 8 +: 8], 8'h00};
                for (int k = 0; k < 8; k++)
                    c = c[15] ? ((c << 1) ^ poly) : (c << 1);
            end
            return c;
        endfunction

        function void push(logic [1:0] kind, logic [15:0] crc, logic [4:0] idx,
                           logic [63:0] chunk, logic last);
            t_result r;
            r.kind = kind;
            r.crc = crc;
            r.page = page;
            r.idx = idx;
            r.chunk = chunk;
            r.last = last;
            pending.push_back(r);
        endfunction

        function void note_command(logic [2:0] req, logic [15:0] pg, logic [3:0] len,
                                   logic [63:0] data);
            logic [63:0] mask;
            int unsigned n;
            case (phase)
                PH_AWAIT: begin
                    if (req == REQ_START) begin
                        page = pg;
                        slot = 1;
                        phase = PH_RECV;
                    end else if (req == REQ_ACTIVATE) begin
                        phase = PH_FINISHED;
                        push(KIND_FINISHED, 16'd0, 5'd0, 64'd0, 1'b1);
                    end
                end
                PH_RECV: begin
                    if (req == REQ_DATA) begin
                        n = (len > MAX_LEN) ? MAX_LEN : len;
                        mask = (n == 8) ? '1 : ((64'd1 << (n * 8)) - 1);
                        buffer[slot - 1] = (buffer[slot - 1] & ~mask) | (data & mask);
                        slot++;
                        if (slot > SLOTS) begin
                            slot = 1;
                            phase = PH_DONE;
                            push(KIND_DATA_ACK, page_crc(), 5'd0, 64'd0, 1'b1);
                        end
                    end
                end
                PH_DONE: begin
                    if (req == REQ_PROGRAM) begin
                        for (int s = 0; s < SLOTS; s++)
                            push(KIND_CHUNK, 16'd0, s[4:0], buffer[s], 1'b0);
                        push(KIND_PROG_ACK, 16'd0, 5'd0, 64'd0, 1'b1);
                        phase = PH_AWAIT;
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic [103:0] tdata, logic [1:0] tuser, logic tlast);
            t_result e;
            t_result a;
            a.kind = tuser;
            a.crc = tdata[15:0];
            a.page = tdata[31:16];
            a.idx = tdata[36:32];
            a.chunk = tdata[100:37];
            a.last = tlast;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word %h", $realtime, a);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a !== e) begin
                $display("%0t: mismatch expected kind %0d crc %h page %h idx %0d data %h last %b",
                         $realtime, e.kind, e.crc, e.page, e.idx, e.chunk, e.last);
                $display("%0t:            actual kind %0d crc %h page %h idx %0d data %h last %b",
                         $realtime, a.kind, a.crc, a.page, a.idx, a.chunk, a.last);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [0:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata = '0;
    logic [2:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         m_axis_tlast;

    download_scoreboard sb = new();
    bit quiet = 1'b0;
    int unsigned hold_request = 0;
    int unsigned hold_left = 0;
    int unsigned items = 0;

    block_download_receiver uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver readiness, with a long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= quiet || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end

    initial begin
        #2ms;
        $display("block_download_receiver test failed");
        $finish;
    end

    task automatic send(logic [2:0] req, logic [15:0] pg, logic [3:0] len, logic [63:0] data);
        while (!quiet && $urandom_range(99) < 27) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= req;
        s_axis_tdata <= {4'd0, data, len, pg};
        forever begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        sb.note_command(req, pg, len, data);
        items++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] index, logic [15:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.configure(index, value);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // One session: start, data until the page fills, then program.
    task automatic run_block(logic [15:0] pg, bit fixed_len);
        send(REQ_START, pg, 4'($urandom), rand64());
        while (sb.phase == PH_RECV) begin
            if ($urandom_range(99) < 10)
                send(3'($urandom), 16'($urandom), 4'($urandom), rand64());
            else if (fixed_len || $urandom_range(99) < 60)
                send(REQ_DATA, 16'($urandom), 4'd8, rand64());
            else
                send(REQ_DATA, 16'($urandom), 4'($urandom), rand64());
        end
        if ($urandom_range(99) < 50)
            send($urandom_range(1) ? REQ_START : REQ_ACTIVATE, 16'($urandom),
                 4'($urandom), rand64());
        send(REQ_PROGRAM, 16'($urandom), 4'($urandom), rand64());
    endtask

    initial begin
        logic [15:0] poly_vals [4] = '{16'h0000, 16'hFFFF, 16'h8005, 16'h1021};
        logic [15:0] init_vals [4] = '{16'hFFFF, 16'h0000, 16'h1D0F, 16'hFFFF};
        int blk;
        sb.clear();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Stray commands before any block, then a page filled with edge lengths.
        for (int r = 4; r < 8; r++) send(r[2:0], 16'hFFFF, 4'hF, '1);
        send(REQ_DATA, 16'd0, 4'd8, '1);
        send(REQ_PROGRAM, 16'd0, 4'd0, 64'd0);
        send(REQ_START, 16'hFFFF, 4'd0, 64'd0);
        send(REQ_START, 16'h1234, 4'd0, 64'd0);
        send(REQ_ACTIVATE, 16'd0, 4'd0, 64'd0);
        send(REQ_PROGRAM, 16'd0, 4'd0, 64'd0);
        for (int s = 0; s < SLOTS; s++)
            send(REQ_DATA, 16'd0, s[3:0], (s % 2) ? 64'hFFFF_FFFF_FFFF_FFFF : rand64());
        send(REQ_DATA, 16'd0, 4'd8, 64'd0);
        send(REQ_PROGRAM, 16'd0, 4'd0, 64'd0);
        wait_drained();

        blk = 0;
        while (items < 410) begin
            if (blk < 4) begin
                write_reg(CFG_POLY, poly_vals[blk]);
                write_reg(CFG_INIT, init_vals[blk]);
            end else if (blk % 3 == 0) begin
                // Settings change only once every pending CRC has been reported.
                wait_drained();
                write_reg(1'($urandom_range(1)), 16'($urandom));
            end
            quiet = (blk == 5);
            if (blk == 7) begin
                // Receiver stalls while the next session is already being offered.
                run_block(16'($urandom), 1'b0);
                hold_request = 600;
                run_block(16'h0000, 1'b1);
            end else begin
                run_block((blk == 2) ? 16'hFFFF : 16'($urandom), blk == 1);
            end
            if (blk % 2 == 0 || blk < 8) wait_drained();
            blk++;
        end
        quiet = 1'b0;
        wait_drained();

        send(REQ_ACTIVATE, 16'($urandom), 4'($urandom), rand64());
        for (int n = 0; n < 8; n++) send(n[2:0], 16'($urandom), 4'($urandom), rand64());
        wait_drained();
        repeat (100) @(negedge i_clk);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("block_download_receiver test passed");
        end else begin
            $display("block_download_receiver test failed");
        end
        $finish;
    end
endmodule
